// ----- src/qiac_pkg.sv -----
// Shared definitions for the quadrature index/alignment counter.
// Holds command codes, register indexes, reset values and the result beat type.
// No dependencies.
`default_nettype none

package qiac_pkg;

  // Command codes carried in the mode field.
  localparam logic [1:0] MODE_EVENT    = 2'd0;
  localparam logic [1:0] MODE_CLEAR    = 2'd1;
  localparam logic [1:0] MODE_SNAPSHOT = 2'd2;

  // Axis selection for the clear command.
  localparam logic AXIS_ZI = 1'b0;
  localparam logic AXIS_C  = 1'b1;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LOCKOUT = 1'd1;

  localparam int unsigned LOCKOUT_W     = 15;
  localparam int unsigned CFG_DATA_W    = LOCKOUT_W;
  localparam logic [LOCKOUT_W-1:0] LOCKOUT_RESET = 15'd25;

  localparam int unsigned COUNT_WIDTH_DEF = 32;
  localparam int unsigned INDEX_W = 16;
  localparam int unsigned PINS_W  = 4;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned OUT_W   = 32;

  // Pin bit positions.
  localparam int unsigned PIN_A     = 0;
  localparam int unsigned PIN_B     = 1;
  localparam int unsigned PIN_INDEX = 2;
  localparam int unsigned PIN_ALIGN = 3;

  typedef struct packed {
    logic signed [OUT_W-1:0]   z_count;
    logic signed [OUT_W-1:0]   c_count;
    logic signed [INDEX_W-1:0] index_count;
    logic [PINS_W-1:0]         pin_state;
  } res_t;

endpackage

`default_nettype wire

// ----- src/quadrature_index_align_counter.sv -----
// Quadrature encoder counter with index and alignment-sensor lockout.
// Results are registered in the output head, or in the skid stage if the head stalls.
// Throughput: one command beat per cycle unless in_stall_o is high; the state update
// is a single add and compare stage; input stalls once both buffer entries are full.
// Reset: counts, pin record and lockout time clear to zero, enable clears, lockout is 25 ms.
`default_nettype none

module quadrature_index_align_counter import qiac_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = COUNT_WIDTH_DEF
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  input  wire logic                  in_valid_i,
  output logic                       in_stall_o,
  input  wire logic [1:0]            mode_i,
  input  wire logic [PINS_W-1:0]     pins_i,
  input  wire logic [TIME_W-1:0]     now_ms_i,
  input  wire logic                  reset_axis_i,
  output logic                       out_valid_o,
  input  wire logic                  out_stall_i,
  output logic signed [OUT_W-1:0]    z_count_o,
  output logic signed [OUT_W-1:0]    c_count_o,
  output logic signed [INDEX_W-1:0]  index_count_o,
  output logic [PINS_W-1:0]          pin_state_o
);

  logic                   enable_q;
  logic [LOCKOUT_W-1:0]   lockout_q;
  logic [PINS_W-1:0]      prev_pins_q, prev_pins_d;
  logic                   old_b_q, old_b_d;
  logic [COUNT_WIDTH-1:0] z_q, z_d;
  logic [INDEX_W-1:0]     index_q, index_d;
  logic [COUNT_WIDTH-1:0] align_q, align_d;
  logic [TIME_W-1:0]      last_ms_q, last_ms_d;
  logic                   in_acc;
  logic                   buf_full;
  res_t                   res;
  res_t                   out_data;

  assign in_stall_o = buf_full;
  assign in_acc     = in_valid_i && !buf_full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q  <= 1'b0;
      lockout_q <= LOCKOUT_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ENABLE:  enable_q  <= cfg_wdata_i[0];
        REG_LOCKOUT: lockout_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  qiac_update #(
    .CountWidth (COUNT_WIDTH)
  ) u_update (
    .mode_i       (mode_i),
    .pins_i       (pins_i),
    .now_ms_i     (now_ms_i),
    .reset_axis_i (reset_axis_i),
    .enable_i     (enable_q),
    .lockout_i    (lockout_q),
    .prev_pins_i  (prev_pins_q),
    .old_b_i      (old_b_q),
    .z_i          (z_q),
    .index_i      (index_q),
    .align_i      (align_q),
    .last_ms_i    (last_ms_q),
    .prev_pins_o  (prev_pins_d),
    .old_b_o      (old_b_d),
    .z_o          (z_d),
    .index_o      (index_d),
    .align_o      (align_d),
    .last_ms_o    (last_ms_d),
    .res_o        (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_pins_q <= '0;
      old_b_q     <= 1'b0;
      z_q         <= '0;
      index_q     <= '0;
      align_q     <= '0;
      last_ms_q   <= '0;
    end else if (in_acc) begin
      prev_pins_q <= prev_pins_d;
      old_b_q     <= old_b_d;
      z_q         <= z_d;
      index_q     <= index_d;
      align_q     <= align_d;
      last_ms_q   <= last_ms_d;
    end
  end

  qiac_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (in_acc),
    .push_data_i (res),
    .full_o      (buf_full),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data)
  );

  assign z_count_o     = out_data.z_count;
  assign c_count_o     = out_data.c_count;
  assign index_count_o = out_data.index_count;
  assign pin_state_o   = out_data.pin_state;

  // A beat can only sit in the skid stage behind a held head beat.
  a_skid_behind_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    buf_full |-> out_valid_o)
    else $error("skid beat without a head beat");

  // A pin event while disabled leaves the position count alone.
  a_disabled_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == MODE_EVENT && !enable_q) |=> $stable(z_q))
    else $error("position moved while disabled");

  // A snapshot records the sampled pins.
  a_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == MODE_SNAPSHOT) |=> (prev_pins_q == $past(pins_i)))
    else $error("snapshot did not record pins");

  // Clearing the Z axis zeroes both position and index counts.
  a_clear_zi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && mode_i == MODE_CLEAR && reset_axis_i == AXIS_ZI)
      |=> (z_q == '0 && index_q == '0))
    else $error("Z axis clear failed");

endmodule

`default_nettype wire

// ----- src/qiac_update.sv -----
// Next-state and result logic for one command beat of the counter.
// Purely combinational; depends on qiac_pkg.
`default_nettype none

module qiac_update import qiac_pkg::*; #(
  parameter int unsigned CountWidth = COUNT_WIDTH_DEF
) (
  input  wire logic [1:0]            mode_i,
  input  wire logic [PINS_W-1:0]     pins_i,
  input  wire logic [TIME_W-1:0]     now_ms_i,
  input  wire logic                  reset_axis_i,
  input  wire logic                  enable_i,
  input  wire logic [LOCKOUT_W-1:0]  lockout_i,
  input  wire logic [PINS_W-1:0]     prev_pins_i,
  input  wire logic                  old_b_i,
  input  wire logic [CountWidth-1:0] z_i,
  input  wire logic [INDEX_W-1:0]    index_i,
  input  wire logic [CountWidth-1:0] align_i,
  input  wire logic [TIME_W-1:0]     last_ms_i,
  output logic [PINS_W-1:0]          prev_pins_o,
  output logic                       old_b_o,
  output logic [CountWidth-1:0]      z_o,
  output logic [INDEX_W-1:0]         index_o,
  output logic [CountWidth-1:0]      align_o,
  output logic [TIME_W-1:0]          last_ms_o,
  output res_t                       res_o
);

  logic [PINS_W-1:0] change;
  logic              ab_change;
  logic              dir_up;
  logic [TIME_W-1:0] limit;
  logic              lock_pass;
  logic [OUT_W-1:0]  z_ext;
  logic [OUT_W-1:0]  c_ext;

  assign change    = pins_i ^ prev_pins_i;
  assign ab_change = change[PIN_A] | change[PIN_B];
  assign dir_up    = pins_i[PIN_A] ^ old_b_i;
  // The limit wraps at 32 bits; an earlier clock value means the clock rolled over.
  assign limit     = last_ms_i + TIME_W'(lockout_i);
  assign lock_pass = (now_ms_i > limit) || (now_ms_i < last_ms_i);

  always_comb begin
    prev_pins_o = prev_pins_i;
    old_b_o     = old_b_i;
    z_o         = z_i;
    index_o     = index_i;
    align_o     = align_i;
    last_ms_o   = last_ms_i;
    case (mode_i)
      MODE_EVENT: begin
        if (enable_i) begin
          if (ab_change) begin
            old_b_o = pins_i[PIN_B];
            z_o     = dir_up ? z_i + CountWidth'(1) : z_i - CountWidth'(1);
          end
          // The index count only moves when A or B moved in the same beat.
          if (change[PIN_INDEX] && pins_i[PIN_INDEX] && ab_change) begin
            index_o = dir_up ? index_i + INDEX_W'(1) : index_i - INDEX_W'(1);
          end
          if (change[PIN_ALIGN] && lock_pass) begin
            last_ms_o = now_ms_i;
            if (!pins_i[PIN_ALIGN]) begin
              align_o = align_i + CountWidth'(1);
            end
          end
          prev_pins_o = pins_i;
        end
      end
      MODE_CLEAR: begin
        if (reset_axis_i == AXIS_ZI) begin
          z_o     = '0;
          index_o = '0;
        end else begin
          align_o = '0;
        end
      end
      MODE_SNAPSHOT: begin
        prev_pins_o = pins_i;
      end
      default: begin
      end
    endcase
  end

  // Counts are reported sign-extended from their width, cut to 32 bits.
  if (CountWidth >= OUT_W) begin : g_wide
    assign z_ext = z_o[OUT_W-1:0];
    assign c_ext = align_o[OUT_W-1:0];
  end else begin : g_narrow
    assign z_ext = {{(OUT_W-CountWidth){z_o[CountWidth-1]}}, z_o};
    assign c_ext = {{(OUT_W-CountWidth){align_o[CountWidth-1]}}, align_o};
  end

  always_comb begin
    res_o.z_count     = z_ext;
    res_o.c_count     = c_ext;
    res_o.index_count = index_o;
    res_o.pin_state   = prev_pins_o;
  end

endmodule

`default_nettype wire

// ----- src/qiac_out_buf.sv -----
// Output register with a skid stage for result beats.
// Depends on qiac_pkg for the result type.
`default_nettype none

module qiac_out_buf import qiac_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire res_t push_data_i,
  output logic      full_o,
  output logic      out_valid_o,
  input  wire logic out_stall_i,
  output res_t      out_data_o
);

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (!out_valid_q || !out_stall_i) begin
      // The head is free this cycle; the skid beat is older and goes first.
      out_valid_q  <= skid_valid_q || push_i;
      skid_valid_q <= 1'b0;
    end else if (push_i) begin
      skid_valid_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!out_valid_q || !out_stall_i) begin
      out_q <= skid_valid_q ? skid_q : push_data_i;
    end else if (push_i) begin
      skid_q <= push_data_i;
    end
  end

  assign full_o      = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire
